// ----- sv/tah_pkg.sv -----
// Shared beat types and field constants for the Heron triangle area core.
package tah_pkg;

    localparam int COORD_IN_W = 16;
    localparam int LEN_W      = 17;
    localparam int AREA_W     = 33;

    localparam logic [LEN_W-1:0]  LEN_MAX  = '1;
    localparam logic [AREA_W-1:0] AREA_MAX = '1;

    typedef struct packed {
        logic signed [COORD_IN_W-1:0] ax;
        logic signed [COORD_IN_W-1:0] ay;
        logic signed [COORD_IN_W-1:0] az;
        logic signed [COORD_IN_W-1:0] bx;
        logic signed [COORD_IN_W-1:0] by_coord;
        logic signed [COORD_IN_W-1:0] bz;
        logic signed [COORD_IN_W-1:0] cx;
        logic signed [COORD_IN_W-1:0] cy;
        logic signed [COORD_IN_W-1:0] cz;
    } tah_in_t;

    typedef struct packed {
        logic [LEN_W-1:0]  len_ab;
        logic [LEN_W-1:0]  len_bc;
        logic [LEN_W-1:0]  len_ca;
        logic [AREA_W-1:0] tri_area;
        logic              degenerate;
    } tah_out_t;

endpackage

// ----- sv/tah_isqrt.sv -----
// Pipelined restoring integer square root, one result bit per stage.
module tah_isqrt
    import tah_pkg::*;
#(
    parameter int IN_W  = 34,
    parameter int TAG_W = 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [IN_W-1:0]      radicand,
    input  logic [TAG_W-1:0]     in_tag,
    output logic                 out_valid,
    output logic [IN_W/2-1:0]    root,
    output logic [TAG_W-1:0]     out_tag
);

    localparam int RW = IN_W / 2;
    localparam int MW = RW + 2;

    logic              vld_w  [0:RW];
    logic [IN_W-1:0]   rad_w  [0:RW];
    logic [MW-1:0]     rem_w  [0:RW];
    logic [RW-1:0]     root_w [0:RW];
    logic [TAG_W-1:0]  tag_w  [0:RW];

    assign vld_w[0]  = in_valid;
    assign rad_w[0]  = radicand;
    assign rem_w[0]  = '0;
    assign root_w[0] = '0;
    assign tag_w[0]  = in_tag;

    for (genvar s = 0; s < RW; s++)
    begin : g_stage
        logic [MW-1:0]    rem_sh;
        logic [MW-1:0]    trial;
        logic             fit;
        logic [MW-1:0]    rem_next;
        logic [RW-1:0]    root_next;
        logic             vld_reg;
        logic [IN_W-1:0]  rad_reg;
        logic [MW-1:0]    rem_reg;
        logic [RW-1:0]    root_reg;
        logic [TAG_W-1:0] tag_reg;

        // Bring down the next two radicand bits and try the next root bit.
        always_comb
        begin
            rem_sh    = {rem_w[s][MW-3:0], rad_w[s][IN_W-1 -: 2]};
            trial     = {root_w[s], 2'b01};
            fit       = (rem_sh >= trial);
            rem_next  = fit ? (rem_sh - trial) : rem_sh;
            root_next = {root_w[s][RW-2:0], fit};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else if (en)
            begin
                vld_reg <= vld_w[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg  <= rad_w[s] << 2;
                rem_reg  <= rem_next;
                root_reg <= root_next;
                tag_reg  <= tag_w[s];
            end
        end

        assign vld_w[s+1]  = vld_reg;
        assign rad_w[s+1]  = rad_reg;
        assign rem_w[s+1]  = rem_reg;
        assign root_w[s+1] = root_reg;
        assign tag_w[s+1]  = tag_reg;
    end

    assign out_valid = vld_w[RW];
    assign root      = root_w[RW];
    assign out_tag   = tag_w[RW];

endmodule

// ----- sv/tah_dist.sv -----
// Squared edge lengths: differences, squares and sums over three stages.
module tah_dist
    import tah_pkg::*;
#(
    parameter int CW = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  tah_in_t              tri_beat,
    output logic                 out_valid,
    output logic [2*CW+1:0]      sq_ab,
    output logic [2*CW+1:0]      sq_bc,
    output logic [2*CW+1:0]      sq_ca
);

    localparam int DW = CW + 1;
    localparam int XW = (CW > COORD_IN_W) ? CW : COORD_IN_W;

    // Take the low CW bits of a field as a signed coordinate.
    function automatic logic signed [CW-1:0] coord_of(input logic signed [COORD_IN_W-1:0] f);
        logic signed [XW-1:0] e;
        e = XW'(f);
        return e[CW-1:0];
    endfunction

    function automatic logic [DW-1:0] diff_mag(input logic signed [CW-1:0] x,
                                               input logic signed [CW-1:0] y);
        logic signed [DW-1:0] d;
        d = DW'(x) - DW'(y);
        return d[DW-1] ? DW'(-d) : DW'(d);
    endfunction

    logic signed [CW-1:0] crd [0:8];
    logic [DW-1:0]   mag_next [0:8];
    logic [DW-1:0]   mag_reg  [0:8];
    logic [2*DW-1:0] sq_reg   [0:8];
    logic [2*DW-1:0] sum_reg  [0:2];
    logic [2:0]      vld_reg;

    always_comb
    begin
        crd[0] = coord_of(tri_beat.ax);
        crd[1] = coord_of(tri_beat.ay);
        crd[2] = coord_of(tri_beat.az);
        crd[3] = coord_of(tri_beat.bx);
        crd[4] = coord_of(tri_beat.by_coord);
        crd[5] = coord_of(tri_beat.bz);
        crd[6] = coord_of(tri_beat.cx);
        crd[7] = coord_of(tri_beat.cy);
        crd[8] = coord_of(tri_beat.cz);
        // Lanes 0-2 are A-B, 3-5 are B-C, 6-8 are C-A.
        for (int k = 0; k < 3; k++)
        begin
            mag_next[k]     = diff_mag(crd[k],     crd[k + 3]);
            mag_next[k + 3] = diff_mag(crd[k + 3], crd[k + 6]);
            mag_next[k + 6] = diff_mag(crd[k + 6], crd[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 9; k++)
            begin
                mag_reg[k] <= mag_next[k];
                sq_reg[k]  <= mag_reg[k] * mag_reg[k];
            end
            for (int e = 0; e < 3; e++)
            begin
                sum_reg[e] <= sq_reg[3*e] + sq_reg[3*e + 1] + sq_reg[3*e + 2];
            end
        end
    end

    assign out_valid = vld_reg[2];
    assign sq_ab     = sum_reg[0];
    assign sq_bc     = sum_reg[1];
    assign sq_ca     = sum_reg[2];

endmodule

// ----- sv/tah_heron.sv -----
// Heron product in four stages, then its pipelined root and area saturation.
module tah_heron
    import tah_pkg::*;
#(
    parameter int CW = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [CW:0]          len_a,
    input  logic [CW:0]          len_b,
    input  logic [CW:0]          len_c,
    output logic                 out_valid,
    output logic [CW:0]          out_a,
    output logic [CW:0]          out_b,
    output logic [CW:0]          out_c,
    output logic [AREA_W-1:0]    area,
    output logic                 degen
);

    localparam int RW  = CW + 1;
    localparam int FW  = CW + 4;
    localparam int MW  = CW + 3;
    localparam int PW  = 4 * MW;
    localparam int TW  = 3 * RW + 1;
    localparam int QW  = 2 * MW - 2;
    localparam int AXW = (QW > AREA_W) ? QW : AREA_W;

    logic signed [FW-1:0] f [0:3];
    logic [MW-1:0]        fmag [0:3];
    logic                 degen_next;
    int unsigned          neg_cnt;

    always_comb
    begin
        f[0] = FW'(len_a) + FW'(len_b) + FW'(len_c);
        f[1] = FW'(len_b) + FW'(len_c) - FW'(len_a);
        f[2] = FW'(len_a) + FW'(len_c) - FW'(len_b);
        f[3] = FW'(len_a) + FW'(len_b) - FW'(len_c);
        neg_cnt    = 0;
        degen_next = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            fmag[k] = f[k][FW-1] ? MW'(-f[k]) : MW'(f[k]);
            if (f[k] == '0)
            begin
                degen_next = 1'b1;
            end
            if (f[k][FW-1])
            begin
                neg_cnt = neg_cnt + 1;
            end
        end
        if (neg_cnt[0])
        begin
            degen_next = 1'b1;
        end
    end

    logic [3:0]        vld_reg;
    logic [TW-1:0]     tag_reg [0:3];
    logic [MW-1:0]     fmag_reg [0:3];
    logic [2*MW-1:0]   p1_reg;
    logic [2*MW-1:0]   p2_reg;
    logic [2*MW-1:0]   pp_reg [0:3];
    logic [PW-1:0]     prod_reg;
    logic [PW-1:0]     prod_next;

    // Sum of partial products lo*lo, lo*hi, hi*lo, hi*hi; zero for a degenerate triangle.
    always_comb
    begin
        prod_next = PW'(pp_reg[0])
                  + ((PW'(pp_reg[1]) + PW'(pp_reg[2])) << MW)
                  + (PW'(pp_reg[3]) << (2 * MW));
        if (tag_reg[2][TW-1])
        begin
            prod_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg[0] <= {degen_next, len_a, len_b, len_c};
            for (int k = 1; k < 4; k++)
            begin
                tag_reg[k] <= tag_reg[k-1];
            end
            for (int k = 0; k < 4; k++)
            begin
                fmag_reg[k] <= fmag[k];
            end
            p1_reg    <= fmag_reg[0] * fmag_reg[1];
            p2_reg    <= fmag_reg[2] * fmag_reg[3];
            pp_reg[0] <= p1_reg[MW-1:0]    * p2_reg[MW-1:0];
            pp_reg[1] <= p1_reg[MW-1:0]    * p2_reg[2*MW-1:MW];
            pp_reg[2] <= p1_reg[2*MW-1:MW] * p2_reg[MW-1:0];
            pp_reg[3] <= p1_reg[2*MW-1:MW] * p2_reg[2*MW-1:MW];
            prod_reg  <= prod_next;
        end
    end

    logic [2*MW-1:0] root;
    logic [TW-1:0]   root_tag;
    logic [AXW-1:0]  area_ext;

    tah_isqrt #(
        .IN_W  (PW),
        .TAG_W (TW)
    ) u_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld_reg[3]),
        .radicand  (prod_reg),
        .in_tag    (tag_reg[3]),
        .out_valid (out_valid),
        .root      (root),
        .out_tag   (root_tag)
    );

    assign area_ext = AXW'(root[2*MW-1:2]);
    assign area     = (area_ext > AXW'(AREA_MAX)) ? AREA_MAX : area_ext[AREA_W-1:0];
    assign degen    = root_tag[TW-1];
    assign out_a    = root_tag[3*RW-1:2*RW];
    assign out_b    = root_tag[2*RW-1:RW];
    assign out_c    = root_tag[RW-1:0];

endmodule

// ----- sv/triangle_area_heron_core.sv -----
// Top level of the Heron triangle area core: distance, root and area pipelines.
// Order: distance stages, edge root stages, Heron product stages, area root stages, output register.
// Throughput: one triangle per cycle while no result is held back; the root pipelines retire one bit per stage.
// All stages advance together whenever the output register is empty or being taken.
// Reset clears only the valid bits; payload registers are not reset.
module triangle_area_heron_core
    import tah_pkg::*;
#(
    parameter int COORD_WIDTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      tri_valid,
    output logic      tri_ready,
    input  tah_in_t   tri_data,
    output logic      res_valid,
    input  logic      res_ready,
    output tah_out_t  res_data
);

    localparam int RW = COORD_WIDTH + 1;
    localparam int EW = 2 * COORD_WIDTH + 2;
    localparam int SW = (RW > LEN_W) ? RW : LEN_W;

    // Saturate a length to the result field.
    function automatic logic [LEN_W-1:0] sat_len(input logic [RW-1:0] l);
        logic [SW-1:0] e;
        e = SW'(l);
        return (e > SW'(LEN_MAX)) ? LEN_MAX : e[LEN_W-1:0];
    endfunction

    logic res_valid_reg;
    tah_out_t res_reg;

    // One enable moves the whole pipeline. It is low only when a finished
    // result sits in the output register and the consumer does not take it,
    // so every beat in flight holds its place and nothing is lost or repeated.
    logic en;
    assign en        = !res_valid_reg || res_ready;
    assign tri_ready = en;

    // Squared lengths of edges AB, BC and CA.
    logic          d_valid;
    logic [EW-1:0] sq_ab;
    logic [EW-1:0] sq_bc;
    logic [EW-1:0] sq_ca;

    tah_dist #(
        .CW (COORD_WIDTH)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (tri_valid),
        .tri_beat  (tri_data),
        .out_valid (d_valid),
        .sq_ab     (sq_ab),
        .sq_bc     (sq_bc),
        .sq_ca     (sq_ca)
    );

    // Three root pipelines run in lockstep; the first one's valid is used.
    logic [2:0]    e_valid;
    logic [RW-1:0] len_ab;
    logic [RW-1:0] len_bc;
    logic [RW-1:0] len_ca;
    logic          unused_tag [0:2];

    tah_isqrt #(.IN_W (EW), .TAG_W (1)) u_root_ab (
        .clk (clk), .rst_n (rst_n), .en (en), .in_valid (d_valid),
        .radicand (sq_ab), .in_tag (1'b0),
        .out_valid (e_valid[0]), .root (len_ab), .out_tag (unused_tag[0])
    );

    tah_isqrt #(.IN_W (EW), .TAG_W (1)) u_root_bc (
        .clk (clk), .rst_n (rst_n), .en (en), .in_valid (d_valid),
        .radicand (sq_bc), .in_tag (1'b0),
        .out_valid (e_valid[1]), .root (len_bc), .out_tag (unused_tag[1])
    );

    tah_isqrt #(.IN_W (EW), .TAG_W (1)) u_root_ca (
        .clk (clk), .rst_n (rst_n), .en (en), .in_valid (d_valid),
        .radicand (sq_ca), .in_tag (1'b0),
        .out_valid (e_valid[2]), .root (len_ca), .out_tag (unused_tag[2])
    );

    // Heron's formula with a = BC, b = CA, c = AB. The lengths ride along
    // with the product so they leave in step with the area.
    logic              h_valid;
    logic [RW-1:0]     h_a;
    logic [RW-1:0]     h_b;
    logic [RW-1:0]     h_c;
    logic [AREA_W-1:0] h_area;
    logic              h_degen;

    tah_heron #(
        .CW (COORD_WIDTH)
    ) u_heron (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (e_valid[0]),
        .len_a     (len_bc),
        .len_b     (len_ca),
        .len_c     (len_ab),
        .out_valid (h_valid),
        .out_a     (h_a),
        .out_b     (h_b),
        .out_c     (h_c),
        .area      (h_area),
        .degen     (h_degen)
    );

    // Output register. Its valid is reloaded whenever the pipeline moves, its payload only with a valid result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            res_valid_reg <= h_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && h_valid)
        begin
            res_reg.len_ab     <= sat_len(h_c);
            res_reg.len_bc     <= sat_len(h_a);
            res_reg.len_ca     <= sat_len(h_b);
            res_reg.tri_area   <= h_area;
            res_reg.degenerate <= h_degen;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    // The edge root pipelines for AB, BC and CA must never drift apart.
    a_edges_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (e_valid[0] == e_valid[1]) && (e_valid[0] == e_valid[2]))
        else $error("edge root pipelines out of step");

    // A degenerate triangle always reports zero area.
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.degenerate) |-> (res_data.tri_area == '0))
        else $error("degenerate result with nonzero area");

    // The input side stalls only behind a result that is held back.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !tri_ready |-> (res_valid && !res_ready))
        else $error("input stalled without an output stall");

    // A held result does not lose its valid while the consumer waits.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> res_valid)
        else $error("held result dropped");

endmodule

// ----- bench/tb_triangle_area_heron_core.sv -----
// Self-checking testbench for the Heron triangle area core.
`timescale 1ns / 1ps

module tb_triangle_area_heron_core;
    import tah_pkg::*;

    localparam int CW        = 16;
    localparam int LATENCY   = 63;
    localparam int WDOG_MAX  = 5000;
    localparam int N_RANDOM  = 1200;

    logic     clk;
    logic     rst_n;
    logic     tri_valid;
    logic     tri_ready;
    tah_in_t  tri_data;
    logic     res_valid;
    logic     res_ready;
    tah_out_t res_data;

    triangle_area_heron_core #(.COORD_WIDTH(CW)) i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .tri_valid (tri_valid),
        .tri_ready (tri_ready),
        .tri_data  (tri_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    tah_in_t  pending_tris[$];
    tah_out_t expected_results[$];
    int       n_mismatch;
    bit       hold_sender;
    int       idle_cycles;

    // Append one triangle to the sender's queue.
    task automatic queue_tri(input tah_in_t t);
        pending_tris.insert(pending_tris.size(), t);
    endtask

    // Floor square root of a 128-bit value, one bit at a time from the top.
    function automatic logic [63:0] floor_root(input logic [127:0] v);
        logic [63:0]  r;
        logic [63:0]  c;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            c = r | (64'd1 << i);
            if ({64'd0, c} * {64'd0, c} <= v)
                r = c;
        end
        return r;
    endfunction

    function automatic longint sext_coord(input logic [COORD_IN_W-1:0] raw);
        logic [CW-1:0] v;
        v = raw[CW-1:0];
        return longint'($signed(v));
    endfunction

    function automatic logic [63:0] edge_length(input longint x0, y0, z0, x1, y1, z1);
        longint dx;
        longint dy;
        longint dz;
        dx = x0 - x1;
        dy = y0 - y1;
        dz = z0 - z1;
        return floor_root(128'(dx * dx + dy * dy + dz * dz));
    endfunction

    // Expected lengths, area and degenerate flag for one triangle.
    function automatic tah_out_t heron_predict(input tah_in_t t);
        longint      axv, ayv, azv, bxv, byv, bzv, cxv, cyv, czv;
        logic [63:0] lab, lbc, lca, root;
        longint      a, b, c;
        longint      f[4];
        bit          zero;
        int          neg;
        logic [127:0] prod;
        tah_out_t    r;
        axv = sext_coord(t.ax);
        ayv = sext_coord(t.ay);
        azv = sext_coord(t.az);
        bxv = sext_coord(t.bx);
        byv = sext_coord(t.by_coord);
        bzv = sext_coord(t.bz);
        cxv = sext_coord(t.cx);
        cyv = sext_coord(t.cy);
        czv = sext_coord(t.cz);
        lab = edge_length(axv, ayv, azv, bxv, byv, bzv);
        lbc = edge_length(bxv, byv, bzv, cxv, cyv, czv);
        lca = edge_length(cxv, cyv, czv, axv, ayv, azv);
        a = longint'(lbc);
        b = longint'(lca);
        c = longint'(lab);
        f[0] = a + b + c;
        f[1] = b + c - a;
        f[2] = a + c - b;
        f[3] = a + b - c;
        zero = 1'b0;
        neg = 0;
        for (int i = 0; i < 4; i++)
        begin
            if (f[i] == 0)
                zero = 1'b1;
            if (f[i] < 0)
                neg++;
        end
        r.degenerate = zero || neg[0];
        r.tri_area = '0;
        if (!r.degenerate)
        begin
            // Products of magnitudes; an even count of negative factors gives a positive P.
            prod = 128'(f[0] < 0 ? -f[0] : f[0]) * 128'(f[1] < 0 ? -f[1] : f[1])
                 * 128'(f[2] < 0 ? -f[2] : f[2]) * 128'(f[3] < 0 ? -f[3] : f[3]);
            root = floor_root(prod) >> 2;
            r.tri_area = (root > 64'(AREA_MAX)) ? AREA_MAX : root[AREA_W-1:0];
        end
        r.len_ab = (lab > 64'(LEN_MAX)) ? LEN_MAX : lab[LEN_W-1:0];
        r.len_bc = (lbc > 64'(LEN_MAX)) ? LEN_MAX : lbc[LEN_W-1:0];
        r.len_ca = (lca > 64'(LEN_MAX)) ? LEN_MAX : lca[LEN_W-1:0];
        return r;
    endfunction

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic tah_in_t rand_tri();
        tah_in_t t;
        t.ax = rand_coord();
        t.ay = rand_coord();
        t.az = rand_coord();
        t.bx = rand_coord();
        t.by_coord = rand_coord();
        t.bz = rand_coord();
        t.cx = rand_coord();
        t.cy = rand_coord();
        t.cz = rand_coord();
        case ($urandom_range(0, 7))
            // Coincident corners.
            0: begin t.bx = t.ax; t.by_coord = t.ay; t.bz = t.az; end
            // Coincident corners B and C.
            1: begin t.cx = t.bx; t.cy = t.by_coord; t.cz = t.bz; end
            default: ;
        endcase
        return t;
    endfunction

    function automatic tah_in_t make_tri(input int ax, ay, az, bx, by, bz,
                                         cx, cy, cz);
        tah_in_t t;
        t.ax = ax[15:0]; t.ay = ay[15:0]; t.az = az[15:0];
        t.bx = bx[15:0]; t.by_coord = by[15:0]; t.bz = bz[15:0];
        t.cx = cx[15:0]; t.cy = cy[15:0]; t.cz = cz[15:0];
        return t;
    endfunction

    // Sender: bursts of random length separated by random gaps.
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tri_valid  <= 1'b0;
            tri_data   <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (!tri_valid || tri_ready)
            begin
                if (gap_left > 0)
                begin
                    tri_valid <= 1'b0;
                    gap_left  <= gap_left - 1;
                end
                else if (pending_tris.size() > 0 && !hold_sender)
                begin
                    tri_valid <= 1'b1;
                    tri_data  <= pending_tris.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    tri_valid <= 1'b0;
            end
        end
    end

    // The prediction is made on the beat that the core accepts.
    always @(posedge clk)
    begin
        if (rst_n && tri_valid && tri_ready)
            expected_results.insert(expected_results.size(), heron_predict(tri_data));
    end

    // Receiver stall pattern: long ready stretches, long stalls and random flicker.
    int stall_mode_left;
    int stall_mode;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready       <= 1'b0;
            stall_mode_left <= 0;
            stall_mode      <= 0;
        end
        else
        begin
            if (stall_mode_left == 0)
            begin
                stall_mode      <= $urandom_range(0, 3);
                stall_mode_left <= $urandom_range(10, 80);
            end
            else
                stall_mode_left <= stall_mode_left - 1;
            case (stall_mode)
                0: res_ready <= 1'b1;
                1: res_ready <= ($urandom_range(0, 9) != 0);
                2: res_ready <= 1'($urandom_range(0, 1));
                default: res_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Monitor: compare each result beat with the oldest prediction.
    always @(posedge clk)
    begin
        tah_out_t exp_r;
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_results.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result beat: %p", res_data);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (res_data !== exp_r)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: expected %p, got %p", exp_r, res_data);
                end
            end
        end
    end

    // Watchdog on cycles in which no beat is accepted on either side.
    always @(posedge clk)
    begin
        if ((tri_valid && tri_ready) || (res_valid && res_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("[triangle_area_heron_core] ERROR");
            $finish;
        end
    end

    initial
    begin
        n_mismatch  = 0;
        hold_sender = 1'b0;
        idle_cycles = 0;
        rst_n       = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed triangles: extremes, degenerate shapes and plain right triangles.
        queue_tri(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_tri(make_tri(0, 0, 0, 16'h0300, 0, 0, 0, 16'h0400, 0));
        queue_tri(make_tri(0, 0, 0, 16'h0100, 0, 0, 16'h0200, 0, 0));
        queue_tri(make_tri(16'h8000, 16'h8000, 16'h8000,
                           16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0, 0));
        queue_tri(make_tri(16'h8000, 16'h8000, 16'h8000,
                           16'h7FFF, 16'h7FFF, 16'h7FFF,
                           16'h8000, 16'h7FFF, 16'h8000));
        queue_tri(make_tri(16'h8000, 0, 0, 16'h7FFF, 0, 0, 0, 16'h7FFF, 0));
        queue_tri(make_tri(16'h8000, 16'h8000, 0, 16'h7FFF, 16'h8000, 0,
                           16'h8000, 16'h7FFF, 16'h7FFF));
        queue_tri(make_tri(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h5555, 16'hAAAA,
                           16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
        queue_tri(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
        queue_tri(make_tri(0, 0, 0, 1, 1, 0, 2, 2, 1));
        queue_tri(make_tri(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                           16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000));
        queue_tri(make_tri(16'h0100, 16'h0100, 16'h0100, 16'h0100,
                           16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'h0100));

        // Let the directed part drain fully before random traffic starts.
        wait (pending_tris.size() == 0);
        hold_sender = 1'b1;
        wait (expected_results.size() == 0 && !tri_valid);
        @(posedge clk);
        hold_sender = 1'b0;

        for (int i = 0; i < N_RANDOM; i++)
        begin
            queue_tri(rand_tri());
            if (i == N_RANDOM / 2)
            begin
                wait (pending_tris.size() == 0);
                hold_sender = 1'b1;
                wait (expected_results.size() == 0 && !tri_valid);
                @(posedge clk);
                hold_sender = 1'b0;
            end
        end

        wait (pending_tris.size() == 0 && !tri_valid);
        wait (expected_results.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);

        if (n_mismatch == 0 && expected_results.size() == 0)
            $display("[triangle_area_heron_core] OK");
        else
            $display("[triangle_area_heron_core] ERROR");
        $finish;
    end

endmodule
